FILE: hw/rtl/vau_pkg.sv
package vau_pkg;

    // Component width of every Q value
    localparam int Q_W    = 32;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // Operation codes
    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_SCALE = 3'd2;
    localparam logic [2:0] CMD_DOT   = 3'd3;
    localparam logic [2:0] CMD_CROSS = 3'd4;
    localparam logic [2:0] CMD_LEN   = 3'd5;
    localparam logic [2:0] CMD_NORM  = 3'd6;
    localparam logic [2:0] CMD_DIST  = 3'd7;

    typedef struct packed {
        logic [2:0]        cmd;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale_factor;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_scalar;
        logic               saturated;
    } rsp_t;

    // Clamp to the signed 32-bit range; top bit flags a clamp
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -66'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

FILE: hw/rtl/vau_isqrt.sv
// Pipelined integer square root, one root bit per stage
module vau_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [vau_pkg::RAD_W-1:0]     rad,
    output logic [vau_pkg::ROOT_W-1:0]    root
);

    localparam int SQ = vau_pkg::ROOT_W;

    logic [33:0]               rem_reg  [SQ];
    logic [SQ-1:0]             root_reg [SQ];
    logic [vau_pkg::RAD_W-1:0] rad_reg  [SQ];

    genvar k;
    generate
        for (k = 0; k < SQ; k++)
        begin : g_stage
            logic [33:0]               rem_in;
            logic [SQ-1:0]             root_in;
            logic [vau_pkg::RAD_W-1:0] rad_in;
            logic [35:0]               t;
            logic [35:0]               trial;
            logic [35:0]               diff;
            logic                      ge;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = rad;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rad_in  = rad_reg[k-1];
            end

            // Bring down two radicand bits and try the next root bit
            assign t     = {rem_in, rad_in[vau_pkg::RAD_W-1 -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign diff  = t - trial;
            assign ge    = (t >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[33:0] : t[33:0];
                    root_reg[k] <= {root_in[SQ-2:0], ge};
                    rad_reg[k]  <= {rad_in[vau_pkg::RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[SQ-1];

endmodule

FILE: hw/rtl/vau_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit QW bits: num >> QW is below den.
module vau_div #(
    parameter int QW = 17
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [vau_pkg::Q_W+QW-1:0]   num,
    input  logic [vau_pkg::Q_W-1:0]      den,
    output logic [QW-1:0]                quo
);

    localparam int DW = vau_pkg::Q_W;

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] den_reg [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] q_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   t;
            logic [DW:0]   diff;
            logic          ge;

            if (j == 0)
            begin : g_first
                assign rem_in = num[DW+QW-1:QW];
                assign low_in = num[QW-1:0];
                assign q_in   = '0;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[j-1];
                assign low_in = low_reg[j-1];
                assign q_in   = q_reg[j-1];
                assign den_in = den_reg[j-1];
            end

            // Shift in the next numerator bit and subtract if it fits
            assign t    = {rem_in, low_in[QW-1]};
            assign diff = t - {1'b0, den_in};
            assign ge   = (t >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? diff[DW-1:0] : t[DW-1:0];
                    low_reg[j] <= {low_in[QW-2:0], 1'b0};
                    q_reg[j]   <= {q_in[QW-2:0], ge};
                    den_reg[j] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW-1];

endmodule

FILE: hw/rtl/vec3_arithmetic_unit.sv
// Three-component vector ALU on signed fixed point with FRAC_BITS fractional
// bits: add, subtract, scale, dot, cross, length, normalize and distance.
// One request enters every cycle unless the pipeline stalls, and each gives
// exactly one response, in order. Requests pass the 32-stage square root,
// one root bit per stage, and the FRAC_BITS + 1 stage divider that normalize
// uses on their way to the output register. All operations travel the full
// pipeline. A two-entry output buffer lets the block take requests while a
// response waits; the pipeline stalls only when both entries are full. Length
// and distance clamp to the 32-bit range and set saturated; normalize of a
// zero-length vector returns the zero vector.
module vec3_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  vau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output vau_pkg::rsp_t rsp
);

    localparam int SQ   = vau_pkg::ROOT_W;
    localparam int QW   = FRAC_BITS + 1;
    localparam int NW   = vau_pkg::Q_W + QW;
    localparam int NSTG = 5 + SQ + QW;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic [2:0]        cmd;
        logic [31:0]       res_x;
        logic [31:0]       res_y;
        logic [31:0]       res_z;
        logic [31:0]       res_s;
        logic              sat;
        logic [2:0][31:0]  mag;
        logic [2:0]        sgn;
        logic              zero;
    } side_t;

    logic            adv;
    logic            push;
    logic            pop;
    logic [NSTG-1:0] valid_reg;

    // Stage 1: request register
    vau_pkg::req_t in_reg;

    // Stage 2: sums and differences, multiplier operands
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [32:0] dsum [3];
    logic [32:0]        dcl [3];
    logic [2:0]         cmd2_reg;
    logic [2:0][31:0]   vec2_next, vec2_reg;
    logic               sat2_next, sat2_reg;
    logic signed [31:0] opa2_next [6];
    logic signed [31:0] opb2_next [6];
    logic signed [31:0] opa2_reg  [6];
    logic signed [31:0] opb2_reg  [6];
    logic [2:0][31:0]   mag2_next, mag2_reg;
    logic [2:0]         sgn2_next, sgn2_reg;

    // Stage 3: products
    logic [2:0]         cmd3_reg;
    logic [2:0][31:0]   vec3_reg;
    logic               sat3_reg;
    logic signed [63:0] prod3_reg [6];
    logic [2:0][31:0]   mag3_reg;
    logic [2:0]         sgn3_reg;

    // Stage 4: rounded products, partial sum of squares
    logic [2:0]         cmd4_reg;
    logic [2:0][31:0]   vec4_reg;
    logic               sat4_reg;
    logic signed [63:0] rnd4_reg [6];
    logic [63:0]        sq01_reg;
    logic [63:0]        sq2_reg;
    logic [2:0][31:0]   mag4_reg;
    logic [2:0]         sgn4_reg;

    // Stage 5: combine and clamp
    side_t              side5_next, side5_reg;
    logic [63:0]        rad5_reg;
    logic [32:0]        cl5 [3];

    // Root and divider stages
    side_t              side_reg [SQ+QW];
    side_t              post_next;
    logic [31:0]        root;
    logic [NW-1:0]      num [3];
    logic [QW-1:0]      quo [3];
    side_t              fin_side;
    vau_pkg::rsp_t      fin;

    // Output buffer
    logic               rsp_valid_reg;
    logic               skid_valid_reg;
    vau_pkg::rsp_t      rsp_data_reg;
    vau_pkg::rsp_t      skid_data_reg;

    // Advance the whole pipeline while the spare output entry is free
    assign adv       = !skid_valid_reg;
    assign req_ready = adv;
    assign pop       = rsp_valid_reg && rsp_ready;
    assign push      = valid_reg[NSTG-1] && adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= req;
        end
    end

    // Form sums and differences, pick multiplier operands
    always_comb
    begin
        av[0] = in_reg.a_x;
        av[1] = in_reg.a_y;
        av[2] = in_reg.a_z;
        bv[0] = in_reg.b_x;
        bv[1] = in_reg.b_y;
        bv[2] = in_reg.b_z;
        for (int i = 0; i < 3; i++)
        begin
            if (in_reg.cmd == vau_pkg::CMD_ADD)
                dsum[i] = 33'(av[i]) + 33'(bv[i]);
            else
                dsum[i] = 33'(av[i]) - 33'(bv[i]);
            dcl[i]       = vau_pkg::sat32(66'(dsum[i]));
            vec2_next[i] = dcl[i][31:0];
            sgn2_next[i] = av[i][31];
            mag2_next[i] = av[i][31] ? (~av[i] + 32'd1) : av[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            opa2_next[i] = '0;
            opb2_next[i] = '0;
        end
        sat2_next = 1'b0;
        unique case (in_reg.cmd)
            vau_pkg::CMD_ADD, vau_pkg::CMD_SUB:
            begin
                sat2_next = dcl[0][32] | dcl[1][32] | dcl[2][32];
            end
            vau_pkg::CMD_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa2_next[i] = av[i];
                    opb2_next[i] = in_reg.scale_factor;
                end
            end
            vau_pkg::CMD_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa2_next[i] = av[i];
                    opb2_next[i] = bv[i];
                end
            end
            vau_pkg::CMD_CROSS:
            begin
                opa2_next[0] = av[1]; opb2_next[0] = bv[2];
                opa2_next[1] = av[2]; opb2_next[1] = bv[1];
                opa2_next[2] = av[2]; opb2_next[2] = bv[0];
                opa2_next[3] = av[0]; opb2_next[3] = bv[2];
                opa2_next[4] = av[0]; opb2_next[4] = bv[1];
                opa2_next[5] = av[1]; opb2_next[5] = bv[0];
            end
            vau_pkg::CMD_LEN, vau_pkg::CMD_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa2_next[i] = av[i];
                    opb2_next[i] = av[i];
                end
            end
            vau_pkg::CMD_DIST:
            begin
                sat2_next = dcl[0][32] | dcl[1][32] | dcl[2][32];
                for (int i = 0; i < 3; i++)
                begin
                    opa2_next[i] = dcl[i][31:0];
                    opb2_next[i] = dcl[i][31:0];
                end
            end
        endcase
    end

    // Advance stages 2 to 4
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd2_reg <= in_reg.cmd;
            vec2_reg <= vec2_next;
            sat2_reg <= sat2_next;
            mag2_reg <= mag2_next;
            sgn2_reg <= sgn2_next;
            for (int i = 0; i < 6; i++)
            begin
                opa2_reg[i]  <= opa2_next[i];
                opb2_reg[i]  <= opb2_next[i];
                prod3_reg[i] <= opa2_reg[i] * opb2_reg[i];
                rnd4_reg[i]  <= (prod3_reg[i] + HALF) >>> FRAC_BITS;
            end
            cmd3_reg <= cmd2_reg;
            vec3_reg <= vec2_reg;
            sat3_reg <= sat2_reg;
            mag3_reg <= mag2_reg;
            sgn3_reg <= sgn2_reg;
            cmd4_reg <= cmd3_reg;
            vec4_reg <= vec3_reg;
            sat4_reg <= sat3_reg;
            mag4_reg <= mag3_reg;
            sgn4_reg <= sgn3_reg;
            sq01_reg <= $unsigned(prod3_reg[0]) + $unsigned(prod3_reg[1]);
            sq2_reg  <= $unsigned(prod3_reg[2]);
        end
    end

    // Combine rounded products and clamp
    always_comb
    begin
        side5_next       = '0;
        side5_next.cmd   = cmd4_reg;
        side5_next.sat   = sat4_reg;
        side5_next.mag   = mag4_reg;
        side5_next.sgn   = sgn4_reg;
        for (int i = 0; i < 3; i++)
            cl5[i] = '0;
        unique case (cmd4_reg)
            vau_pkg::CMD_ADD, vau_pkg::CMD_SUB:
            begin
                side5_next.res_x = vec4_reg[0];
                side5_next.res_y = vec4_reg[1];
                side5_next.res_z = vec4_reg[2];
            end
            vau_pkg::CMD_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    cl5[i] = vau_pkg::sat32(66'(rnd4_reg[i]));
            end
            vau_pkg::CMD_DOT:
            begin
                cl5[0] = vau_pkg::sat32(66'(rnd4_reg[0]) + 66'(rnd4_reg[1])
                                        + 66'(rnd4_reg[2]));
                side5_next.res_s = cl5[0][31:0];
                side5_next.sat   = cl5[0][32];
            end
            vau_pkg::CMD_CROSS:
            begin
                cl5[0] = vau_pkg::sat32(66'(rnd4_reg[0]) - 66'(rnd4_reg[1]));
                cl5[1] = vau_pkg::sat32(66'(rnd4_reg[2]) - 66'(rnd4_reg[3]));
                cl5[2] = vau_pkg::sat32(66'(rnd4_reg[4]) - 66'(rnd4_reg[5]));
            end
            vau_pkg::CMD_LEN, vau_pkg::CMD_NORM, vau_pkg::CMD_DIST:
            begin
                side5_next.sat = sat4_reg;
            end
        endcase
        if (cmd4_reg == vau_pkg::CMD_SCALE || cmd4_reg == vau_pkg::CMD_CROSS)
        begin
            side5_next.res_x = cl5[0][31:0];
            side5_next.res_y = cl5[1][31:0];
            side5_next.res_z = cl5[2][31:0];
            side5_next.sat   = cl5[0][32] | cl5[1][32] | cl5[2][32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side5_reg <= side5_next;
            rad5_reg  <= sq01_reg + sq2_reg;
        end
    end

    vau_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad5_reg),
        .root (root)
    );

    // Clamp the length, build the normalize numerators
    always_comb
    begin
        post_next      = side_reg[SQ-1];
        post_next.zero = (root == '0);
        if (post_next.cmd == vau_pkg::CMD_LEN || post_next.cmd == vau_pkg::CMD_DIST)
        begin
            if (root[31])
            begin
                post_next.res_s = 32'h7FFF_FFFF;
                post_next.sat   = 1'b1;
            end
            else
            begin
                post_next.res_s = root;
            end
        end
        for (int i = 0; i < 3; i++)
            num[i] = (NW'(post_next.mag[i]) << FRAC_BITS) + NW'(root >> 1);
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            vau_div #(
                .QW (QW)
            ) u_div (
                .clk (clk),
                .en  (adv),
                .num (num[g]),
                .den (root),
                .quo (quo[g])
            );
        end
    endgenerate

    // Carry the side data alongside root and divider stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0]  <= side5_reg;
            side_reg[SQ] <= post_next;
            for (int k = 1; k < SQ; k++)
                side_reg[k] <= side_reg[k-1];
            for (int k = SQ + 1; k < SQ + QW; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // Apply signs to the normalized components
    always_comb
    begin
        fin_side       = side_reg[SQ+QW-1];
        fin.res_x      = fin_side.res_x;
        fin.res_y      = fin_side.res_y;
        fin.res_z      = fin_side.res_z;
        fin.res_scalar = fin_side.res_s;
        fin.saturated  = fin_side.sat;
        if (fin_side.cmd == vau_pkg::CMD_NORM && !fin_side.zero)
        begin
            fin.res_x = fin_side.sgn[0] ? -32'(quo[0]) : 32'(quo[0]);
            fin.res_y = fin_side.sgn[1] ? -32'(quo[1]) : 32'(quo[1]);
            fin.res_z = fin_side.sgn[2] ? -32'(quo[2]) : 32'(quo[2]);
        end
    end

    // Output register and spare entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (rsp_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                rsp_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                rsp_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (rsp_valid_reg && !pop)
                skid_data_reg <= fin;
            else
                rsp_data_reg <= fin;
        end
    end

    // The spare entry only holds a response behind a waiting one
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("spare entry full with output empty");

    // The spare entry fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(rsp_valid_reg && !rsp_ready))
        else $error("spare entry filled without a stall");

    // Scalar operations leave the vector zero
    a_scalar_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTG-1] && (fin_side.cmd == vau_pkg::CMD_DOT
            || fin_side.cmd == vau_pkg::CMD_LEN || fin_side.cmd == vau_pkg::CMD_DIST))
        |-> (fin.res_x == '0 && fin.res_y == '0 && fin.res_z == '0))
        else $error("scalar operation with non-zero vector");

    // Length and distance are never negative
    a_len_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTG-1] && (fin_side.cmd == vau_pkg::CMD_LEN
            || fin_side.cmd == vau_pkg::CMD_DIST)) |-> !fin.res_scalar[31])
        else $error("negative length");

    // Normalize never clamps
    a_norm_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTG-1] && fin_side.cmd == vau_pkg::CMD_NORM) |-> !fin.saturated)
        else $error("normalize flagged saturation");

endmodule

FILE: tb/vec3_arithmetic_unit_tb.sv
module vec3_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam int N_RANDOM = 1350;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    vau_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    vau_pkg::rsp_t rsp;

    vau_pkg::rsp_t expected_q[$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_idle_pct;

    vec3_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Clamp to 32 bits, noting any clamp
    function automatic logic signed [31:0] clamp_q(input longint v, inout bit sat);
        if (v > QMAX)
        begin
            sat = 1'b1;
            return PMAX;
        end
        if (v < QMIN)
        begin
            sat = 1'b1;
            return PMIN;
        end
        return v[31:0];
    endfunction

    // Rounded Q product, halves toward +infinity
    function automatic longint q_product(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned vec_length(input longint x, input longint y,
                                                   input longint z);
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned uz;
        ux = x < 0 ? -x : x;
        uy = y < 0 ? -y : y;
        uz = z < 0 ? -z : z;
        return root_floor(ux * ux + uy * uy + uz * uz);
    endfunction

    function automatic logic signed [31:0] unit_comp(input longint c,
                                                     input longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = c < 0 ? -c : c;
        q = ((m << FRAC) + (len >> 1)) / len;
        return 32'(c < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint len_to_q(input longint unsigned len);
        return len > 64'd2147483647 ? QMAX + 1 : longint'(len);
    endfunction

    // Work out the response to one request
    function automatic vau_pkg::rsp_t vector_result(input vau_pkg::req_t r);
        vau_pkg::rsp_t o;
        bit sat;
        longint ax, ay, az, bx, by, bz, s;
        longint dx, dy, dz;
        longint unsigned len;
        ax = r.a_x; ay = r.a_y; az = r.a_z;
        bx = r.b_x; by = r.b_y; bz = r.b_z;
        s = r.scale_factor;
        o = '0;
        sat = 1'b0;
        case (r.cmd)
            vau_pkg::CMD_ADD:
            begin
                o.res_x = clamp_q(ax + bx, sat);
                o.res_y = clamp_q(ay + by, sat);
                o.res_z = clamp_q(az + bz, sat);
            end
            vau_pkg::CMD_SUB:
            begin
                o.res_x = clamp_q(ax - bx, sat);
                o.res_y = clamp_q(ay - by, sat);
                o.res_z = clamp_q(az - bz, sat);
            end
            vau_pkg::CMD_SCALE:
            begin
                o.res_x = clamp_q(q_product(ax, s), sat);
                o.res_y = clamp_q(q_product(ay, s), sat);
                o.res_z = clamp_q(q_product(az, s), sat);
            end
            vau_pkg::CMD_DOT:
                o.res_scalar = clamp_q(q_product(ax, bx) + q_product(ay, by)
                                       + q_product(az, bz), sat);
            vau_pkg::CMD_CROSS:
            begin
                o.res_x = clamp_q(q_product(ay, bz) - q_product(az, by), sat);
                o.res_y = clamp_q(q_product(az, bx) - q_product(ax, bz), sat);
                o.res_z = clamp_q(q_product(ax, by) - q_product(ay, bx), sat);
            end
            vau_pkg::CMD_LEN:
                o.res_scalar = clamp_q(len_to_q(vec_length(ax, ay, az)), sat);
            vau_pkg::CMD_NORM:
            begin
                len = vec_length(ax, ay, az);
                if (len != 0)
                begin
                    o.res_x = unit_comp(ax, len);
                    o.res_y = unit_comp(ay, len);
                    o.res_z = unit_comp(az, len);
                end
            end
            default:
            begin
                dx = clamp_q(ax - bx, sat);
                dy = clamp_q(ay - by, sat);
                dz = clamp_q(az - bz, sat);
                o.res_scalar = clamp_q(len_to_q(vec_length(dx, dy, dz)), sat);
            end
        endcase
        o.saturated = sat;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? PMAX : PMIN;
            2: return $signed($urandom_range(0, 8'hFF)) - 128;
            3: return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 32'h0004_0000));
            4: return $signed($urandom) >>> $urandom_range(0, 31);
            default: return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    // Hand one request over, holding it until taken
    task automatic send_request(input vau_pkg::req_t r);
        while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        expected_q.push_back(vector_result(r));
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Drive receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(1, 100) <= recv_idle_pct);
    end

    // Compare each response with the oldest expectation
    always @(posedge clk)
    begin
        vau_pkg::rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (rsp.res_x !== e.res_x || rsp.res_y !== e.res_y
                    || rsp.res_z !== e.res_z || rsp.res_scalar !== e.res_scalar
                    || rsp.saturated !== e.saturated)
                begin
                    $display("%0t: mismatch expected x=%h y=%h z=%h s=%h sat=%b",
                             $time, e.res_x, e.res_y, e.res_z, e.res_scalar, e.saturated);
                    $display("%0t:          actual   x=%h y=%h z=%h s=%h sat=%b",
                             $time, rsp.res_x, rsp.res_y, rsp.res_z, rsp.res_scalar,
                             rsp.saturated);
                    fail_count++;
                end
            end
        end
    end

    typedef struct {
        vau_pkg::req_t r;
        bit            has_rsp;
        vau_pkg::rsp_t rs;
    } row_t;

    row_t rows[$];

    function automatic vau_pkg::req_t mk(input logic [2:0] c, input logic signed [31:0] ax,
                                input logic signed [31:0] ay, input logic signed [31:0] az,
                                input logic signed [31:0] bx, input logic signed [31:0] by,
                                input logic signed [31:0] bz, input logic signed [31:0] s);
        vau_pkg::req_t r;
        r.cmd = c; r.a_x = ax; r.a_y = ay; r.a_z = az;
        r.b_x = bx; r.b_y = by; r.b_z = bz; r.scale_factor = s;
        return r;
    endfunction

    function automatic vau_pkg::rsp_t mr(input logic signed [31:0] x,
                                input logic signed [31:0] y,
                                input logic signed [31:0] z, input logic signed [31:0] s,
                                input logic f);
        vau_pkg::rsp_t o;
        o.res_x = x; o.res_y = y; o.res_z = z; o.res_scalar = s; o.saturated = f;
        return o;
    endfunction

    task automatic add_row(input vau_pkg::req_t r, input bit k, input vau_pkg::rsp_t o);
        row_t w;
        w.r = r; w.has_rsp = k; w.rs = o;
        rows.push_back(w);
    endtask

    initial
    begin
        vau_pkg::req_t r;
        int wait_cycles;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Directed table: known answers where obvious, predictor elsewhere
        add_row(mk(vau_pkg::CMD_ADD, PMAX, PMIN, 1, 1, -1, 2, 0), 1,
                mr(PMAX, PMIN, 3, 0, 1));
        add_row(mk(vau_pkg::CMD_SUB, PMIN, PMAX, 0, 1, -1, 0, 0), 1,
                mr(PMIN, PMAX, 0, 0, 1));
        add_row(mk(vau_pkg::CMD_SCALE, ONE, -ONE, 0, 0, 0, 0, ONE), 1,
                mr(ONE, -ONE, 0, 0, 0));
        add_row(mk(vau_pkg::CMD_SCALE, PMAX, PMIN, PMIN, 0, 0, 0, PMIN), 1,
                mr(PMIN, PMAX, PMAX, 0, 1));
        add_row(mk(vau_pkg::CMD_DOT, ONE, ONE, ONE, ONE, ONE, ONE, 0), 1,
                mr(0, 0, 0, 3 * ONE, 0));
        add_row(mk(vau_pkg::CMD_DOT, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0), 1,
                mr(0, 0, 0, PMAX, 1));
        add_row(mk(vau_pkg::CMD_CROSS, ONE, 0, 0, 0, ONE, 0, 0), 1, mr(0, 0, ONE, 0, 0));
        add_row(mk(vau_pkg::CMD_CROSS, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, 0), 0, '0);
        add_row(mk(vau_pkg::CMD_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0), 1,
                mr(0, 0, 0, 5 * ONE, 0));
        add_row(mk(vau_pkg::CMD_LEN, PMIN, PMIN, PMIN, 0, 0, 0, 0), 1,
                mr(0, 0, 0, PMAX, 1));
        add_row(mk(vau_pkg::CMD_LEN, 0, 0, 0, 0, 0, 0, 0), 1, mr(0, 0, 0, 0, 0));
        add_row(mk(vau_pkg::CMD_NORM, 0, 0, 0, 5, 5, 5, 5), 1, mr(0, 0, 0, 0, 0));
        add_row(mk(vau_pkg::CMD_NORM, -5 * ONE, 0, 0, 0, 0, 0, 0), 1,
                mr(-ONE, 0, 0, 0, 0));
        add_row(mk(vau_pkg::CMD_NORM, 1, -1, 1, 0, 0, 0, 0), 0, '0);
        add_row(mk(vau_pkg::CMD_NORM, PMIN, PMAX, PMIN, 0, 0, 0, 0), 0, '0);
        add_row(mk(vau_pkg::CMD_DIST, PMAX, 0, 0, PMIN, 0, 0, 0), 1,
                mr(0, 0, 0, PMAX, 1));
        add_row(mk(vau_pkg::CMD_DIST, ONE, ONE, ONE, ONE, ONE, ONE, 0), 1,
                mr(0, 0, 0, 0, 0));
        add_row(mk(vau_pkg::CMD_DIST, 3 * ONE, 0, 0, 0, -4 * ONE, 0, 0), 1,
                mr(0, 0, 0, 5 * ONE, 0));
        add_row(mk(vau_pkg::CMD_SCALE, -1, 1, -32768, 0, 0, 0, 32768), 0, '0);
        add_row(mk(vau_pkg::CMD_DOT, -1, -1, -1, 32768, 32768, 32768, 0), 0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].has_rsp && vector_result(rows[i].r) !== rows[i].rs)
            begin
                $display("%0t: table row %0d expected %h predicted %h", $time, i,
                         rows[i].rs, vector_result(rows[i].r));
                fail_count++;
            end
            send_request(rows[i].r);
        end

        // Random requests over three idling phases
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 0) begin send_idle_pct = 14; recv_idle_pct = 70; end
            if (n == N_RANDOM / 3) begin send_idle_pct = 70; recv_idle_pct = 14; end
            if (n == 2 * N_RANDOM / 3) begin send_idle_pct = 0; recv_idle_pct = 0; end
            r.cmd = 3'($urandom_range(0, 7));
            r.a_x = rand_q(); r.a_y = rand_q(); r.a_z = rand_q();
            r.b_x = rand_q(); r.b_y = rand_q(); r.b_z = rand_q();
            r.scale_factor = rand_q();
            send_request(r);
        end
        req_valid <= 1'b0;

        // Drain, then allow for stragglers
        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);

        if (fail_count == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
